>>> design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    CMD_NOP        = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_REAR  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_REAR   = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } deq_state_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic [1:0]               error_code;
  } rsp_item_t;

  typedef struct packed {
    logic               load;
    logic               empty;
    logic [1:0]         error_code;
    logic [COUNT_W-1:0] entry_count;
  } deq_status_t;

endpackage

`default_nettype wire

>>> design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]  rd_data_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: ring pointers, occupancy, RAM write and read addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH  = 16,
  parameter int IDX_W  = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire deq_pkg::cmd_item_t   cmd,
  input  wire logic                 out_free,
  output logic                      wr_en,
  output logic [IDX_W-1:0]          wr_addr,
  output logic [deq_pkg::WORD_W-1:0] wr_data,
  output logic [IDX_W-1:0]          rd_addr_front,
  output logic [IDX_W-1:0]          rd_addr_rear,
  output deq_pkg::deq_status_t      status
);
  import deq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  deq_state_t       state, state_next;
  logic [IDX_W-1:0] head_index, head_index_next;
  logic [IDX_W-1:0] tail_index, tail_index_next;
  logic [OCC_W-1:0] occupancy, occupancy_next;
  err_code_t        err, err_next;
  logic             accept, full, empty;
  logic [OCC_W+COUNT_W-1:0] occ_ext;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign full   = (occupancy == OCC_W'(DEPTH));
  assign empty  = (occupancy == '0);
  assign accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_index <= '0;
      tail_index <= '0;
      occupancy  <= '0;
      err        <= ERR_OK;
    end else begin
      state      <= state_next;
      head_index <= head_index_next;
      tail_index <= tail_index_next;
      occupancy  <= occupancy_next;
      err        <= err_next;
    end
  end

  always_comb begin
    state_next         = state;
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    occupancy_next     = occupancy;
    err_next           = err;
    cmd_stall          = 1'b1;
    wr_en              = 1'b0;
    wr_addr            = tail_index;
    wr_data            = cmd.value;
    status.load        = 1'b0;
    status.empty       = empty;
    status.error_code  = err;
    status.entry_count = occ_ext[COUNT_W-1:0];
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (accept) begin
          err_next   = ERR_OK;
          state_next = ST_READ;
          case (cmd.command)
            CMD_PUSH_FRONT: begin
              if (full) begin
                err_next = ERR_FULL;
              end else begin
                head_index_next = ring_prev(head_index);
                wr_en           = 1'b1;
                wr_addr         = ring_prev(head_index);
                occupancy_next  = occupancy + 1'b1;
              end
            end
            CMD_PUSH_REAR: begin
              if (full) begin
                err_next = ERR_FULL;
              end else begin
                tail_index_next = ring_next(tail_index);
                wr_en           = 1'b1;
                occupancy_next  = occupancy + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                err_next = ERR_EMPTY;
              end else begin
                head_index_next = ring_next(head_index);
                occupancy_next  = occupancy - 1'b1;
              end
            end
            CMD_POP_REAR: begin
              if (empty) begin
                err_next = ERR_EMPTY;
              end else begin
                tail_index_next = ring_prev(tail_index);
                occupancy_next  = occupancy - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          status.load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // read ports always track the current ends; the RAM registers the read data
  assign rd_addr_front = head_index;
  assign rd_addr_rear  = ring_prev(tail_index);

  assign occ_ext = {{COUNT_W{1'b0}}, occupancy};

endmodule

`default_nettype wire

>>> design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit words with one response per command.
// ----------------------------------------------------------------------------
// Each command runs in steps: the accept step updates the ring pointers and
// writes a pushed word into the RAM, the read step reads both ends from the
// dual-read RAM, and the load step loads the response register. A stalled
// response holds the sequencer in the load step. The next command is
// accepted while a loaded response still waits to be taken. The RAM has no
// reset; only control state is cleared.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire deq_pkg::cmd_item_t cmd,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output deq_pkg::rsp_item_t      rsp
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [IDX_W-1:0]   rd_addr_front, rd_addr_rear;
  logic [WORD_W-1:0]  rd_front, rd_rear;
  logic               out_free;
  deq_status_t        status;

  assign out_free = !rsp_valid || !rsp_stall;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .out_free      (out_free),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr_front (rd_addr_front),
    .rd_addr_rear  (rd_addr_rear),
    .status        (status)
  );

  deq_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_front),
    .rd_data_a (rd_front),
    .rd_addr_b (rd_addr_rear),
    .rd_data_b (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (status.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.load) begin
      rsp.front_value <= status.empty ? '1 : rd_front;
      rsp.rear_value  <= status.empty ? '1 : rd_rear;
      rsp.entry_count <= status.entry_count;
      rsp.is_empty    <= status.empty;
      rsp.error_code  <= status.error_code;
    end
  end

endmodule

`default_nettype wire

>>> design/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_port_checks
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_port_checks #(
  parameter int DEPTH = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_stall,
  input wire deq_pkg::cmd_item_t cmd,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire deq_pkg::rsp_item_t rsp
);
  import deq_pkg::*;

  // stalled response transaction holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // a command transaction keeps the sequencer busy the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted back to back");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      rsp.front_value == -32'sd1 && rsp.rear_value == -32'sd1 &&
      rsp.error_code != ERR_FULL &&
      (DEPTH >= 32 || rsp.entry_count == '0))
    else $error("empty response inconsistent");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code == ERR_EMPTY |-> rsp.is_empty)
    else $error("pop error on non-empty queue");

endmodule

bind double_ended_queue deq_port_checks #(.DEPTH(DEPTH)) u_deq_port_checks (.*);

`default_nettype wire
